### rtl/vbva_pkg.sv
// ----------------------------------------------------------------------------
// vbva_pkg
// shared types, codes and arithmetic helpers of the voxel bin accumulator
// ----------------------------------------------------------------------------
package vbva_pkg;

  // number of cells in the search chain and width of a lane number
  localparam int NCELLS = 4;
  localparam int LANE_W = 2;

  localparam int COORD_W = 13;
  localparam int KEY_W   = 3 * COORD_W;
  localparam int SUM_W   = 32;
  localparam int NORM_W  = 16;
  localparam int ORG_W   = 24;
  localparam int ENTRY_W = KEY_W + 3 * SUM_W;

  // actions carried in the input tuser
  localparam logic [1:0] ACT_CLEAR   = 2'd0;
  localparam logic [1:0] ACT_ADD     = 2'd1;
  localparam logic [1:0] ACT_READ    = 2'd2;
  // taken and dropped, no result
  localparam logic [1:0] ACT_IGNORED = 2'd3;

  // result status codes carried in the output tuser
  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_NEW     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_READ_OK = 3'd3;
  localparam logic [2:0] ST_EMPTY   = 3'd4;
  localparam logic [2:0] ST_CLEARED = 3'd5;

  // what one cell hands to its neighbour
  typedef struct packed {
    logic                    hit;
    logic [LANE_W-1:0]       lane;
    logic [KEY_W-1:0]        key;
    logic signed [SUM_W-1:0] sx;
    logic signed [SUM_W-1:0] sy;
    logic signed [SUM_W-1:0] sz;
  } chain_t;

  // push the origin along the normal and round to the 4096-unit grid
  function automatic logic signed [COORD_W-1:0] quant(
    input logic signed [ORG_W-1:0]  o,
    input logic signed [NORM_W-1:0] n
  );
    logic signed [27:0] t;
    logic        [27:0] m;
    t = $signed({o, 3'b000}) + 28'(n) + 28'sd16384;
    if (!t[27]) begin
      quant = COORD_W'(t >>> 15);
    end else begin
      m = 28'(-t);
      quant = -COORD_W'(m >> 15);
    end
  endfunction

  // saturating add of a normal component to a sum
  function automatic logic signed [SUM_W-1:0] sat_add(
    input logic signed [SUM_W-1:0]  a,
    input logic signed [NORM_W-1:0] n
  );
    logic signed [SUM_W:0] s;
    s = (SUM_W+1)'(a) + (SUM_W+1)'(n);
    if (s[SUM_W] != s[SUM_W-1]) begin
      sat_add = s[SUM_W] ? {1'b1, {(SUM_W-1){1'b0}}} : {1'b0, {(SUM_W-1){1'b1}}};
    end else begin
      sat_add = s[SUM_W-1:0];
    end
  endfunction

endpackage

### rtl/voxel_bin_vector_accumulator.sv
// ----------------------------------------------------------------------------
// voxel_bin_vector_accumulator
// grid cell table that accumulates patch normals per voxel
// ----------------------------------------------------------------------------
// Input requests arrive on in_*: in_tuser is the action (clear, add, read),
// in_tdata the patch origin, normal and slot index. Every clear, add or read
// gives one result on out_*: out_tuser is the status, out_tdata the cell,
// its sums and the occupied count. Action 3 gives no result.
// The table is a chain of four cells, each owning a bank of CAPACITY/4
// slots; slot i lives in cell i mod 4 at row i/4. An add sweeps the rows,
// each by a registered bank read, then a compare along the chain, and
// stops at the first hit or after the last occupied row. A read of an
// occupied slot also takes a registered bank read, then the chain; a read
// past the occupied slots and a clear are answered from the idle state.
// One request is in flight at a time; a new one is accepted once the
// result register is empty, so a stalled receiver holds the block. Reset
// empties the table (count to zero) at once; slot contents need no
// clearing since only occupied slots are looked at.
// ----------------------------------------------------------------------------
module voxel_bin_vector_accumulator #(
  parameter int CAPACITY = 1024
) (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         in_tvalid,
  output logic         in_tready,
  // origin_x, origin_y, origin_z, normal_x, normal_y, normal_z, entry_index
  input  logic [135:0] in_tdata,
  // action
  input  logic [1:0]   in_tuser,
  output logic         out_tvalid,
  input  logic         out_tready,
  // cell_x, cell_y, cell_z, sum_x, sum_y, sum_z, cell_count
  output logic [151:0] out_tdata,
  // status
  output logic [2:0]   out_tuser
);
  import vbva_pkg::*;

  localparam int BANK_DEPTH = CAPACITY / NCELLS;
  localparam int AW         = $clog2(BANK_DEPTH);
  localparam int CW         = $clog2(CAPACITY + 1);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SRD  = 3'd1;
  localparam logic [2:0] S_SCHK = 3'd2;
  localparam logic [2:0] S_RRD  = 3'd3;
  localparam logic [2:0] S_RCHK = 3'd4;

  logic [2:0]  state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [AW-1:0] addr_r, addr_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic signed [NORM_W-1:0] nx_r, ny_r, nz_r, nx_nxt, ny_nxt, nz_nxt;
  logic [LANE_W-1:0] lane_r, lane_nxt;
  logic        out_valid_r, out_valid_nxt;
  logic [2:0]  ost_r, ost_nxt;
  logic [KEY_W-1:0] okey_r, okey_nxt;
  logic signed [SUM_W-1:0] osx_r, osy_r, osz_r, osx_nxt, osy_nxt, osz_nxt;

  logic        accept;
  logic signed [ORG_W-1:0]  ox, oy, oz;
  logic signed [NORM_W-1:0] inx, iny, inz;
  logic [9:0]  idx;
  logic signed [COORD_W-1:0] qx, qy, qz;
  logic        idx_ok;
  logic        sel_mode;

  chain_t chain [NCELLS+1];
  logic [NCELLS-1:0]   wr_en;
  logic [AW-1:0]       wr_addr;
  logic [ENTRY_W-1:0]  wr_data;
  logic                wr_any;
  logic [LANE_W-1:0]   wr_lane;
  logic                last_row;

  // input unpacking
  assign ox  = in_tdata[23:0];
  assign oy  = in_tdata[47:24];
  assign oz  = in_tdata[71:48];
  assign inx = in_tdata[87:72];
  assign iny = in_tdata[103:88];
  assign inz = in_tdata[119:104];
  assign idx = in_tdata[129:120];

  assign qx = quant(ox, inx);
  assign qy = quant(oy, iny);
  assign qz = quant(oz, inz);
  assign idx_ok = (32'(idx) < 32'(count_r)) && (32'(idx) < CAPACITY);

  assign in_tready = (state_r == S_IDLE) && !out_valid_r;
  assign accept    = in_tvalid && in_tready;
  assign sel_mode  = (state_r == S_RRD) || (state_r == S_RCHK);

  // the chain of cells
  assign chain[0] = '0;
  for (genvar c = 0; c < NCELLS; c++) begin : g_cell
    vbva_cell #(
      .LANE       (c),
      .BANK_DEPTH (BANK_DEPTH),
      .CW         (CW)
    ) u_cell (
      .clk       (clk),
      .rd_addr   (addr_r),
      .wr_en     (wr_en[c]),
      .wr_addr   (wr_addr),
      .wr_data   (wr_data),
      .find_key  (key_r),
      .sel_mode  (sel_mode),
      .sel_lane  (lane_r),
      .count     (count_r),
      .chain_in  (chain[c]),
      .chain_out (chain[c+1])
    );
  end

  assign last_row = ((CW+1)'({addr_r, LANE_W'(NCELLS-1)}) + (CW+1)'(1) >= (CW+1)'(count_r))
                    || (addr_r == AW'(BANK_DEPTH-1));

  // sequencer
  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    addr_nxt      = addr_r;
    key_nxt       = key_r;
    nx_nxt        = nx_r;
    ny_nxt        = ny_r;
    nz_nxt        = nz_r;
    lane_nxt      = lane_r;
    out_valid_nxt = out_valid_r && !out_tready;
    ost_nxt       = ost_r;
    okey_nxt      = okey_r;
    osx_nxt       = osx_r;
    osy_nxt       = osy_r;
    osz_nxt       = osz_r;
    wr_any        = 1'b0;
    wr_lane       = '0;
    wr_addr       = addr_r;
    wr_data       = '0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          case (in_tuser)
            ACT_CLEAR: begin
              count_nxt     = '0;
              out_valid_nxt = 1'b1;
              ost_nxt       = ST_CLEARED;
              okey_nxt      = '0;
              osx_nxt       = '0;
              osy_nxt       = '0;
              osz_nxt       = '0;
            end
            ACT_ADD: begin
              key_nxt   = {qx, qy, qz};
              nx_nxt    = inx;
              ny_nxt    = iny;
              nz_nxt    = inz;
              addr_nxt  = '0;
              state_nxt = S_SRD;
            end
            ACT_READ: begin
              if (idx_ok) begin
                addr_nxt  = AW'(idx >> LANE_W);
                lane_nxt  = idx[LANE_W-1:0];
                state_nxt = S_RRD;
              end else begin
                out_valid_nxt = 1'b1;
                ost_nxt       = ST_EMPTY;
                okey_nxt      = '0;
                osx_nxt       = '0;
                osy_nxt       = '0;
                osz_nxt       = '0;
              end
            end
            default: begin
            end
          endcase
        end
      end
      S_SRD: begin
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (chain[NCELLS].hit) begin
          osx_nxt       = sat_add(chain[NCELLS].sx, nx_r);
          osy_nxt       = sat_add(chain[NCELLS].sy, ny_r);
          osz_nxt       = sat_add(chain[NCELLS].sz, nz_r);
          wr_any        = 1'b1;
          wr_lane       = chain[NCELLS].lane;
          wr_addr       = addr_r;
          wr_data       = {key_r, osx_nxt, osy_nxt, osz_nxt};
          ost_nxt       = ST_ADDED;
          okey_nxt      = key_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end else if (last_row) begin
          okey_nxt      = key_r;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
          if (32'(count_r) >= CAPACITY) begin
            ost_nxt = ST_FULL;
            osx_nxt = '0;
            osy_nxt = '0;
            osz_nxt = '0;
          end else begin
            osx_nxt   = SUM_W'(nx_r);
            osy_nxt   = SUM_W'(ny_r);
            osz_nxt   = SUM_W'(nz_r);
            wr_any    = 1'b1;
            wr_lane   = count_r[LANE_W-1:0];
            wr_addr   = AW'(count_r >> LANE_W);
            wr_data   = {key_r, osx_nxt, osy_nxt, osz_nxt};
            ost_nxt   = ST_NEW;
            count_nxt = count_r + CW'(1);
          end
        end else begin
          addr_nxt  = addr_r + AW'(1);
          state_nxt = S_SRD;
        end
      end
      S_RRD: begin
        state_nxt = S_RCHK;
      end
      S_RCHK: begin
        ost_nxt       = ST_READ_OK;
        okey_nxt      = chain[NCELLS].key;
        osx_nxt       = chain[NCELLS].sx;
        osy_nxt       = chain[NCELLS].sy;
        osz_nxt       = chain[NCELLS].sz;
        out_valid_nxt = 1'b1;
        state_nxt     = S_IDLE;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // per-lane write strobes
  always_comb begin
    for (int c = 0; c < NCELLS; c++) begin
      wr_en[c] = wr_any && (wr_lane == LANE_W'(c));
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    addr_r <= addr_nxt;
    key_r  <= key_nxt;
    nx_r   <= nx_nxt;
    ny_r   <= ny_nxt;
    nz_r   <= nz_nxt;
    lane_r <= lane_nxt;
    ost_r  <= ost_nxt;
    okey_r <= okey_nxt;
    osx_r  <= osx_nxt;
    osy_r  <= osy_nxt;
    osz_r  <= osz_nxt;
  end

  // result channel
  assign out_tvalid = out_valid_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {6'd0, 11'(count_r), osz_r, osy_r, osx_r, okey_r[12:0],
                       okey_r[25:13], okey_r[38:26]};

`ifndef ASSERT_OFF
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(count_r) <= CAPACITY)
    else $error("occupied count beyond capacity");
  a_one_write: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0(wr_en))
    else $error("more than one bank written");
  a_clear: assert property (@(posedge clk) disable iff (!rst_n)
    accept && in_tuser == ACT_CLEAR |=> out_valid_r && count_r == '0 && ost_r == ST_CLEARED)
    else $error("clear not completed");
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    state_r != S_IDLE |-> !in_tready && !out_valid_r)
    else $error("request taken while busy");
`endif

endmodule

### rtl/vbva_cell.sv
// ----------------------------------------------------------------------------
// vbva_cell
// one lane of the table: a bank of slots, a key compare and a chain merge
// ----------------------------------------------------------------------------
module vbva_cell #(
  parameter int LANE       = 0,
  parameter int BANK_DEPTH = 256,
  parameter int CW         = 11
) (
  input  logic                                 clk,
  input  logic [$clog2(BANK_DEPTH)-1:0]        rd_addr,
  input  logic                                 wr_en,
  input  logic [$clog2(BANK_DEPTH)-1:0]        wr_addr,
  input  logic [vbva_pkg::ENTRY_W-1:0]         wr_data,
  input  logic [vbva_pkg::KEY_W-1:0]           find_key,
  input  logic                                 sel_mode,
  input  logic [vbva_pkg::LANE_W-1:0]          sel_lane,
  input  logic [CW-1:0]                        count,
  input  vbva_pkg::chain_t                     chain_in,
  output vbva_pkg::chain_t                     chain_out
);
  import vbva_pkg::*;

  localparam int AW = $clog2(BANK_DEPTH);
  localparam logic [LANE_W-1:0] MY_LANE = LANE_W'(LANE);

  logic [ENTRY_W-1:0] mem [BANK_DEPTH];
  logic [ENTRY_W-1:0] rd_data_r;
  logic [AW+LANE_W-1:0] slot;
  logic               slot_valid;
  logic               my_hit;

  // bank: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data_r <= mem[rd_addr];
  end

  // slot number of the entry now on the read data
  assign slot       = {rd_addr, MY_LANE};
  assign slot_valid = CW'(slot) < count;
  assign my_hit     = sel_mode ? (sel_lane == MY_LANE)
                               : (slot_valid && rd_data_r[ENTRY_W-1 -: KEY_W] == find_key);

  // keep an earlier hit, otherwise offer this entry
  always_comb begin
    if (chain_in.hit || !my_hit) begin
      chain_out = chain_in;
    end else begin
      chain_out.hit  = 1'b1;
      chain_out.lane = MY_LANE;
      chain_out.key  = rd_data_r[ENTRY_W-1 -: KEY_W];
      chain_out.sx   = rd_data_r[3*SUM_W-1 -: SUM_W];
      chain_out.sy   = rd_data_r[2*SUM_W-1 -: SUM_W];
      chain_out.sz   = rd_data_r[SUM_W-1:0];
    end
  end

endmodule

### dv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the voxel bin vector accumulator
// ----------------------------------------------------------------------------
// Requests come from a queue that the stimulus process fills: directed corner
// cases, a pass that fills part of the table with distinct cells and hits one
// of them again, then random traffic. Each accepted request
// goes through a behavioural model of the cell table. Every result is
// checked field by field against the oldest predicted one. Both sides idle
// at random. At one point the receiver holds off for a long stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import vbva_pkg::*;

  localparam int TABLE_SIZE = 1024;
  localparam int FILL_CELLS = 120;

  typedef struct {
    logic [1:0]        act;
    logic signed [23:0] ox, oy, oz;
    logic signed [15:0] nx, ny, nz;
    logic [9:0]        idx;
  } patch_req_t;

  typedef struct packed {
    logic [2:0]         st;
    logic signed [12:0] cx, cy, cz;
    logic signed [31:0] sx, sy, sz;
    logic [10:0]        cnt;
  } cell_res_t;

  logic         clk = 1'b0;
  logic         rst_n = 1'b0;
  logic         in_tvalid = 1'b0;
  logic         in_tready;
  logic [135:0] in_tdata = '0;
  logic [1:0]   in_tuser = '0;
  logic         out_tvalid;
  logic         out_tready = 1'b0;
  logic [151:0] out_tdata;
  logic [2:0]   out_tuser;
  logic         hold_off = 1'b0;

  patch_req_t pending_q[$];
  cell_res_t  expected_q[$];
  patch_req_t held_req;

  // model of the cell table
  logic [38:0]        key_mem [TABLE_SIZE];
  logic signed [31:0] sx_mem [TABLE_SIZE];
  logic signed [31:0] sy_mem [TABLE_SIZE];
  logic signed [31:0] sz_mem [TABLE_SIZE];
  int unsigned        occupied;

  int unsigned cycle = 0;
  int unsigned mismatches = 0;

  always #2 clk = ~clk;

  voxel_bin_vector_accumulator uut (
    .clk, .rst_n, .in_tvalid, .in_tready, .in_tdata, .in_tuser,
    .out_tvalid, .out_tready, .out_tdata, .out_tuser
  );

  function automatic logic signed [12:0] grid_cell(input logic signed [23:0] o,
                                                   input logic signed [15:0] n);
    longint t;
    t = longint'(o) * 8 + longint'(n) + 16384;
    if (t >= 0) return 13'(t / 32768);
    return 13'(-((-t) / 32768));
  endfunction

  function automatic logic signed [31:0] clamp_sum(input logic signed [31:0] a,
                                                   input logic signed [15:0] n);
    longint s;
    s = longint'(a) + longint'(n);
    if (s > 64'sd2147483647) return 32'sh7fffffff;
    if (s < -64'sd2147483648) return 32'sh80000000;
    return 32'(s);
  endfunction

  // apply one accepted request to the table model
  task automatic predict_cell(input patch_req_t r);
    cell_res_t   e;
    logic [38:0] key;
    int          hit;
    e = '{st: ST_CLEARED, cx: 0, cy: 0, cz: 0, sx: 0, sy: 0, sz: 0, cnt: 0};
    case (r.act)
      ACT_CLEAR: begin
        occupied = 0;
      end
      ACT_ADD: begin
        e.cx = grid_cell(r.ox, r.nx);
        e.cy = grid_cell(r.oy, r.ny);
        e.cz = grid_cell(r.oz, r.nz);
        key = {e.cx, e.cy, e.cz};
        hit = -1;
        for (int i = 0; i < occupied; i++) if (hit < 0 && key_mem[i] == key) hit = i;
        if (hit >= 0) begin
          sx_mem[hit] = clamp_sum(sx_mem[hit], r.nx);
          sy_mem[hit] = clamp_sum(sy_mem[hit], r.ny);
          sz_mem[hit] = clamp_sum(sz_mem[hit], r.nz);
          e.st = ST_ADDED;
          e.sx = sx_mem[hit]; e.sy = sy_mem[hit]; e.sz = sz_mem[hit];
        end else if (occupied >= TABLE_SIZE) begin
          e.st = ST_FULL;
        end else begin
          key_mem[occupied] = key;
          sx_mem[occupied] = 32'(r.nx);
          sy_mem[occupied] = 32'(r.ny);
          sz_mem[occupied] = 32'(r.nz);
          occupied++;
          e.st = ST_NEW;
          e.sx = 32'(r.nx); e.sy = 32'(r.ny); e.sz = 32'(r.nz);
        end
      end
      ACT_READ: begin
        if (r.idx < occupied) begin
          e.st = ST_READ_OK;
          {e.cx, e.cy, e.cz} = key_mem[r.idx];
          e.sx = sx_mem[r.idx]; e.sy = sy_mem[r.idx]; e.sz = sz_mem[r.idx];
        end else begin
          e.st = ST_EMPTY;
        end
      end
      default: return;
    endcase
    e.cnt = 11'(occupied);
    expected_q.push_back(e);
  endtask

  task automatic queue_patch(input logic [1:0] act, input int ox, oy, oz,
                             input int nx, ny, nz, input int idx);
    patch_req_t r;
    r.act = act;
    r.ox = 24'(ox); r.oy = 24'(oy); r.oz = 24'(oz);
    r.nx = 16'(nx); r.ny = 16'(ny); r.nz = 16'(nz);
    r.idx = 10'(idx);
    pending_q.push_back(r);
  endtask

  function automatic int rand_norm();
    if ($urandom_range(9) == 0) return int'($signed(16'($urandom)));
    return int'($urandom_range(32768)) - 16384;
  endfunction

  function automatic int rand_org();
    if ($urandom_range(7) == 0) return int'($signed(24'($urandom)));
    // a few cells around the origin so hits are common
    return int'($urandom_range(20000)) - 10000;
  endfunction

  // idling pattern shared by both sides, with a quiet window
  function automatic bit idle_now();
    if (cycle >= 3000 && cycle < 9000) return 1'b0;
    return $urandom_range(99) < 25;
  endfunction

  // request driver
  always @(posedge clk) begin
    cycle <= cycle + 1;
    if (rst_n) begin
      if (in_tvalid && in_tready) predict_cell(held_req);
      if (!in_tvalid || in_tready) begin
        if (pending_q.size() > 0 && !idle_now()) begin
          held_req = pending_q.pop_front();
          in_tvalid <= 1'b1;
          in_tuser <= held_req.act;
          in_tdata <= {6'd0, held_req.idx, held_req.nz, held_req.ny, held_req.nx,
                       held_req.oz, held_req.oy, held_req.ox};
        end else begin
          in_tvalid <= 1'b0;
        end
      end
    end
  end

  // long receiver hold-off, counted from the end of reset
  initial begin
    wait (rst_n);
    repeat (1500) @(posedge clk);
    hold_off <= 1'b1;
    repeat (400) @(posedge clk);
    hold_off <= 1'b0;
  end

  // result monitor and receiver stalls
  always @(posedge clk) begin
    cell_res_t e, a;
    if (rst_n) begin
      if (out_tvalid && out_tready) begin
        a.st = out_tuser;
        {a.cnt, a.sz, a.sy, a.sx, a.cz, a.cy, a.cx} = out_tdata[145:0];
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected result status %0d", a.st);
        end else begin
          e = expected_q.pop_front();
          if (a != e) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch exp st%0d c(%0d,%0d,%0d) s(%0d,%0d,%0d) n%0d got st%0d c(%0d,%0d,%0d) s(%0d,%0d,%0d) n%0d",
                       e.st, e.cx, e.cy, e.cz, e.sx, e.sy, e.sz, e.cnt,
                       a.st, a.cx, a.cy, a.cz, a.sx, a.sy, a.sz, a.cnt);
          end
        end
      end
      // long hold-off so the block backs up onto its input
      if (hold_off) out_tready <= 1'b0;
      else out_tready <= !idle_now();
    end
  end

  // stimulus and end of run
  initial begin
    int c;
    // directed corners
    queue_patch(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    queue_patch(ACT_ADD, 8388607, -8388608, 0, 16384, -16384, 0, 0);
    queue_patch(ACT_ADD, 8388607, -8388608, 0, 16384, -16384, 0, 0);
    queue_patch(ACT_ADD, -8388608, 8388607, -1, -16384, 16384, 16384, 0);
    queue_patch(ACT_ADD, 2047, -2048, 2048, 32767, -32768, -1, 0);
    queue_patch(ACT_ADD, -2049, 2049, 0, 0, 0, 0, 0);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 1);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 3);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 4);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 1023);
    queue_patch(ACT_IGNORED, -1, -1, -1, -1, -1, -1, 1023);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    // fill part of the table with distinct cells, then hit one of them
    queue_patch(ACT_CLEAR, 0, 0, 0, 0, 0, 0, 0);
    for (int k = 0; k < FILL_CELLS; k++)
      queue_patch(ACT_ADD, (k - 512) * 4096, k * 4, -k * 4, rand_norm(), rand_norm(),
                  rand_norm(), 0);
    queue_patch(ACT_ADD, 5 * 4096 - 512 * 4096, 0, 0, 100, -100, 7, 0);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 1023);
    queue_patch(ACT_READ, 0, 0, 0, 0, 0, 0, 0);
    // random traffic, mostly adds into a small neighbourhood
    for (int k = 0; k < 500; k++) begin
      c = $urandom_range(99);
      if (c < 2) queue_patch(ACT_CLEAR, rand_org(), 0, 0, 0, 0, 0, $urandom_range(1023));
      else if (c < 4) queue_patch(ACT_IGNORED, rand_org(), rand_org(), rand_org(),
                                  rand_norm(), rand_norm(), rand_norm(),
                                  $urandom_range(1023));
      else if (c < 24) queue_patch(ACT_READ, rand_org(), rand_org(), rand_org(),
                                   rand_norm(), rand_norm(), rand_norm(),
                                   ($urandom_range(3) == 0) ? $urandom_range(1023)
                                                            : $urandom_range(40));
      else queue_patch(ACT_ADD, rand_org(), rand_org(), rand_org(), rand_norm(),
                       rand_norm(), rand_norm(), $urandom_range(1023));
    end

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    while (pending_q.size() > 0 || in_tvalid) @(posedge clk);
    while (expected_q.size() > 0) @(posedge clk);
    repeat (600) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // run limit
  initial begin
    #40ms;
    $display("simulation failed");
    $finish;
  end

endmodule
